/* rtl/core/hcbd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and byte classifiers for the chunked body decoder.
// No dependencies; imported by hcbd_skid and http_chunked_body_decoder.
package hcbd_pkg;

  // Default width of the chunk size and body length counters.
  localparam int LENGTH_BITS_DEF = 24;
  // Width of the reported body length field.
  localparam int OUT_LEN_W = 24;
  // Width of the result tdata bus: byte, status, length, padded to whole bytes.
  localparam int TDATA_W = 40;
  localparam int TDATA_USED = 8 + 2 + OUT_LEN_W;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  // Final status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DATA_LOST = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_SIZE      = 6'b000010,
    PH_SIZE_LINE = 6'b000100,
    PH_DATA      = 6'b001000,
    PH_DATA_END  = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_t;

  // One result item as it waits in the output buffer.
  typedef struct packed {
    logic [OUT_LEN_W-1:0] body_length;
    logic [1:0]           status;
    logic                 done_res;
    logic                 out_valid;
    logic [7:0]           out_byte;
  } result_t;

  // Returns {is_hex, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Space, tab, LF, VT, FF and CR.
  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SP) || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

endpackage

/* rtl/core/http_chunked_body_decoder.sv */
`timescale 1ns / 1ps
// HTTP chunked transfer body decoder, top level.
// Depends on hcbd_pkg and hcbd_skid.
//
// Usage: raw response bytes enter on s_axis, one byte per item, with
// s_axis_tlast on the final byte of a buffered response. Decoded body bytes
// leave on m_axis with m_axis_tuser set; the final result of a message leaves
// with m_axis_tlast set and carries the status and the total body length. A
// body byte and the final result may share one item. Bytes that only carry
// framing produce no output item.
// The single register header_present (reset 1) is written on cfg_valid/
// cfg_ready and restarts the parser; write it only while the block is idle.
// Throughput: one byte per cycle while s_axis_tready is high; the parser state
// is updated in the cycle of acceptance by a short single-pass step. A result
// reaches m_axis from the buffer's main register, via the spare slot on a stall.
// A two-entry output buffer absorbs receiver stalls: s_axis_tready drops only
// once both entries hold results, and rises again when the receiver takes one.
// Reset (rst, synchronous) empties the buffer, sets header_present and puts
// the parser in the header phase.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // in_byte [7:0]
  input  logic [7:0]         s_axis_tdata,
  input  logic               s_axis_tlast,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // out_byte [7:0], status [9:8], body_length [33:10], zeros above
  output logic [TDATA_W-1:0] m_axis_tdata,
  // out_valid [0]
  output logic               m_axis_tuser,
  output logic               m_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Parser state.
  logic                   header_present;
  phase_t                 phase, phase_next;
  logic [1:0]             header_match, header_match_next;
  logic                   cr_seen, cr_seen_next;
  logic                   size_has_digit, size_has_digit_next;
  logic [LENGTH_BITS-1:0] chunk_remaining, chunk_remaining_next;
  logic [LENGTH_BITS-1:0] total_count, total_count_next;
  logic                   overflow_flag, overflow_flag_next;

  logic                   accept;
  logic                   res_byte;
  logic                   res_done;
  logic [1:0]             res_status;
  logic [OUT_LEN_W-1:0]   length_sat;
  logic [4:0]             hex;
  logic                   push;
  logic                   push_ready;
  result_t                res_item;
  result_t                out_item;

  assign cfg_ready = 1'b1;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign hex = hex_digit(s_axis_tdata);

  // One parser step for the byte on the input.
  always_comb begin
    phase_next = phase;
    header_match_next = header_match;
    cr_seen_next = cr_seen;
    size_has_digit_next = size_has_digit;
    chunk_remaining_next = chunk_remaining;
    total_count_next = total_count;
    overflow_flag_next = overflow_flag;
    res_byte = 1'b0;
    res_done = 1'b0;
    res_status = ST_OK;
    case (phase)
      PH_HEADER: begin
        if (s_axis_tdata == CHAR_CR) begin
          header_match_next = (header_match == 2'd0 || header_match == 2'd2) ?
                              header_match + 2'd1 : 2'd1;
        end else if (s_axis_tdata == CHAR_LF && header_match == 2'd1) begin
          header_match_next = 2'd2;
        end else if (s_axis_tdata == CHAR_LF && header_match == 2'd3) begin
          header_match_next = 2'd0;
          phase_next = PH_SIZE;
        end else begin
          header_match_next = 2'd0;
        end
      end
      PH_SIZE: begin
        if (hex[4]) begin
          // A nonzero top nibble means the shifted size no longer fits.
          if (|chunk_remaining[LENGTH_BITS-1 -: 4]) begin
            chunk_remaining_next = LEN_MAX;
            overflow_flag_next = 1'b1;
          end else begin
            chunk_remaining_next = {chunk_remaining[LENGTH_BITS-5:0], hex[3:0]};
          end
          size_has_digit_next = 1'b1;
        end else if (!size_has_digit && is_space(s_axis_tdata)) begin
          // Leading whitespace is skipped.
        end else if (chunk_remaining == '0) begin
          res_done = 1'b1;
          phase_next = PH_DONE;
        end else begin
          cr_seen_next = (s_axis_tdata == CHAR_CR);
          phase_next = PH_SIZE_LINE;
        end
      end
      PH_SIZE_LINE: begin
        cr_seen_next = (s_axis_tdata == CHAR_CR);
        if (cr_seen && s_axis_tdata == CHAR_LF) begin
          cr_seen_next = 1'b0;
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        res_byte = 1'b1;
        if (total_count != LEN_MAX) begin
          total_count_next = total_count + 1'b1;
        end
        if (chunk_remaining != '0) begin
          chunk_remaining_next = chunk_remaining - 1'b1;
        end
        if (chunk_remaining <= LENGTH_BITS'(1)) begin
          cr_seen_next = 1'b0;
          phase_next = PH_DATA_END;
        end
      end
      PH_DATA_END: begin
        cr_seen_next = (s_axis_tdata == CHAR_CR);
        if (cr_seen && s_axis_tdata == CHAR_LF) begin
          cr_seen_next = 1'b0;
          size_has_digit_next = 1'b0;
          chunk_remaining_next = '0;
          phase_next = PH_SIZE;
        end
      end
      default: begin
        // Done phase: bytes are ignored until the last flag.
      end
    endcase

    // The last flag closes a message that has not ended on its own.
    if (s_axis_tlast && phase_next != PH_DONE) begin
      res_done = 1'b1;
      if (phase_next == PH_DATA && chunk_remaining_next != '0) begin
        res_status = ST_DATA_LOST;
      end
    end
    if (res_done && overflow_flag_next) begin
      res_status = ST_OVERFLOW;
    end
  end

  // Body length saturates to the width of the reported field when the counter is wider, else it is zero-extended.
  generate
    if (LENGTH_BITS > OUT_LEN_W) begin : g_len_sat
      assign length_sat = (|total_count_next[LENGTH_BITS-1:OUT_LEN_W]) ?
                          '1 : total_count_next[OUT_LEN_W-1:0];
    end else begin : g_len_ext
      assign length_sat = OUT_LEN_W'(total_count_next);
    end
  endgenerate

  // Result item for the output buffer.
  always_comb begin
    res_item.out_byte = res_byte ? s_axis_tdata : 8'd0;
    res_item.out_valid = res_byte;
    res_item.done_res = res_done;
    res_item.status = res_done ? res_status : ST_OK;
    res_item.body_length = res_done ? length_sat : '0;
  end

  assign push = accept && (res_byte || res_done);
  assign s_axis_tready = push_ready;

  // State registers; the last flag or a configuration write restarts.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_present <= 1'b1;
      phase <= PH_HEADER;
      header_match <= 2'd0;
      cr_seen <= 1'b0;
      size_has_digit <= 1'b0;
      chunk_remaining <= '0;
      total_count <= '0;
      overflow_flag <= 1'b0;
    end else if (cfg_valid || (accept && s_axis_tlast)) begin
      if (cfg_valid) begin
        header_present <= cfg_data;
        phase <= cfg_data ? PH_HEADER : PH_SIZE;
      end else begin
        phase <= header_present ? PH_HEADER : PH_SIZE;
      end
      header_match <= 2'd0;
      cr_seen <= 1'b0;
      size_has_digit <= 1'b0;
      chunk_remaining <= '0;
      total_count <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      header_match <= header_match_next;
      cr_seen <= cr_seen_next;
      size_has_digit <= size_has_digit_next;
      chunk_remaining <= chunk_remaining_next;
      total_count <= total_count_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  hcbd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (push_ready),
    .in_item   (res_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  // Result item onto the master side.
  assign m_axis_tdata = {(TDATA_W - TDATA_USED)'(0), out_item.body_length,
                         out_item.status, out_item.out_byte};
  assign m_axis_tuser = out_item.out_valid;
  assign m_axis_tlast = out_item.done_res;

  // No output item is empty.
  a_no_empty_item: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
    else $error("output item carries neither a byte nor a final result");

  // Status and length are zero unless the item is a final result.
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[TDATA_W-1:8] == '0))
    else $error("status or length set on a non-final item");

  // A byte field is zero when no body byte is carried.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("byte field set on an item without a body byte");

  // An accepted last byte restarts the parser.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=>
      ((phase == PH_HEADER || phase == PH_SIZE) && total_count == '0 &&
       chunk_remaining == '0 && !overflow_flag))
    else $error("parser did not restart after the last byte");

endmodule

/* rtl/core/hcbd_skid.sv */
`timescale 1ns / 1ps
// Two-entry output buffer for result items: a main register and a spare slot.
// Depends on hcbd_pkg for the result_t item type.
module hcbd_skid
  import hcbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  logic    main_valid;
  result_t main_item;
  logic    spare_valid;
  result_t spare_item;

  // Ready depends only on a register, so the two sides stay decoupled.
  assign in_ready = !spare_valid;
  assign out_valid = main_valid;
  assign out_item = main_item;

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (spare_valid) begin
        main_valid <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      spare_valid <= 1'b1;
    end
  end

  // Payload, no reset needed.
  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_item <= spare_valid ? spare_item : in_item;
    end else if (in_valid && in_ready) begin
      spare_item <= in_item;
    end
  end

endmodule
